/* design/wpr_pkg.sv */
// Shared constants, types and helpers for the windowed pulse rate and sample averager.
// No dependencies; wpr_div and the top level refer to this package by scoped names.
`timescale 1ns / 1ps

package wpr_pkg;

  // Ring depth shared by the pulse bins and the sample slots
  localparam int WINDOW_SLOTS = 11;

  localparam int CHANNELS   = 6;
  localparam int SAMPLE_W   = 10;
  localparam int BIN_W      = 16;
  localparam int RING_W     = CHANNELS * SAMPLE_W;
  localparam int IDX_W      = $clog2(WINDOW_SLOTS);

  // Accumulator and divider widths
  localparam int PULSE_SUM_W = BIN_W + IDX_W;
  localparam int CH_SUM_W    = SAMPLE_W + IDX_W;
  localparam int DIV_W       = PULSE_SUM_W + 6;        // room for the x60 scale
  localparam int DV_W        = $clog2(WINDOW_SLOTS + 1);
  localparam int RECIP_W     = DIV_W + 1;              // holds 2^DIV_W for a divisor of one
  localparam int PROD_W      = DIV_W + RECIP_W;
  localparam int LANES       = CHANNELS + 1;           // lane 0 is the pulse rate

  localparam logic [DV_W-1:0] RATE_DIVISOR = DV_W'(WINDOW_SLOTS - 1);
  localparam logic [DV_W-1:0] MEAN_DIVISOR = DV_W'(WINDOW_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(WINDOW_SLOTS - 1);
  localparam logic [BIN_W-1:0] BIN_MAX     = '1;
  localparam int PULSES_PER_MIN_SCALE      = 60;

  // Reciprocals floor(2^DIV_W / divisor); the estimate they give is low by at most one
  localparam logic [RECIP_W-1:0] RATE_RECIP =
    RECIP_W'((longint'(1) << DIV_W) / longint'(WINDOW_SLOTS - 1));
  localparam logic [RECIP_W-1:0] MEAN_RECIP =
    RECIP_W'((longint'(1) << DIV_W) / longint'(WINDOW_SLOTS));

  // Configuration register indexes
  localparam logic [1:0] REG_REPORT_GAP    = 2'd0;
  localparam logic [1:0] REG_BIN_LENGTH    = 2'd1;
  localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd2;

  typedef logic [DIV_W-1:0] div_word_t;
  typedef div_word_t [LANES-1:0] div_lanes_t;

  // Ring index advance with wrap
  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] n;
    n = (i == LAST_IDX) ? '0 : IDX_W'(i + 1'b1);
    return n;
  endfunction

endpackage

/* design/wpr_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module wpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/wpr_div.sv */
// Constant divider for all lanes in parallel: reciprocal multiply, then one correction step.
// Lane 0 divides by the bin count less one, the others by the slot count; uses wpr_pkg.
`timescale 1ns / 1ps

module wpr_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  wpr_pkg::div_lanes_t dividend,
  output wpr_pkg::div_lanes_t quotient,
  output logic                done
);

  wpr_pkg::div_lanes_t        num;
  wpr_pkg::div_lanes_t        est;
  wpr_pkg::div_lanes_t        est_next;
  wpr_pkg::div_lanes_t        quot_next;
  logic [wpr_pkg::PROD_W-1:0] prod [wpr_pkg::LANES];
  logic [wpr_pkg::PROD_W-1:0] back [wpr_pkg::LANES];
  logic [wpr_pkg::DIV_W-1:0]  rem  [wpr_pkg::LANES];
  logic [wpr_pkg::DIV_W-1:0]  dsr  [wpr_pkg::LANES];
  logic                       num_vld;
  logic                       est_vld;

  // Estimate from the reciprocal, then add one where the remainder still holds a divisor
  always_comb begin
    for (int l = 0; l < wpr_pkg::LANES; l++) begin
      dsr[l]       = (l == 0) ? wpr_pkg::DIV_W'(wpr_pkg::RATE_DIVISOR)
                              : wpr_pkg::DIV_W'(wpr_pkg::MEAN_DIVISOR);
      prod[l]      = wpr_pkg::PROD_W'(num[l]) *
                     ((l == 0) ? wpr_pkg::PROD_W'(wpr_pkg::RATE_RECIP)
                               : wpr_pkg::PROD_W'(wpr_pkg::MEAN_RECIP));
      est_next[l]  = prod[l][2*wpr_pkg::DIV_W-1:wpr_pkg::DIV_W];
      back[l]      = wpr_pkg::PROD_W'(est[l]) * wpr_pkg::PROD_W'(dsr[l]);
      rem[l]       = num[l] - back[l][wpr_pkg::DIV_W-1:0];
      quot_next[l] = (rem[l] >= dsr[l]) ? wpr_pkg::DIV_W'(est[l] + 1'b1) : est[l];
    end
  end

  // Stage control: capture, estimate, correct; done holds until the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vld <= 1'b0;
      est_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      num_vld <= start;
      est_vld <= num_vld;
      if (start) begin
        done <= 1'b0;
      end else if (est_vld) begin
        done <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (num_vld) begin
      est <= est_next;
    end
    if (est_vld) begin
      quotient <= quot_next;
    end
  end

endmodule

/* design/windowed_pulse_rate_and_sample_averager.sv */
// Windowed pulse rate meter with six-channel moving average, top level.
// Uses wpr_pkg, wpr_ram (pulse bins and sample ring) and wpr_div (report division).
//
// Each input transaction is a pulse edge (action = 1) or a millisecond tick carrying six
// samples (action = 0). Pulse edges are counted into a ring of WINDOW_SLOTS bins of
// bin_length ms; every sample_period ms a tick's samples go into a ring of WINDOW_SLOTS
// slots. A tick reports once more than report_gap ms have passed since the last report:
// pulse_rate is the pulses of all bins but the current one, times 60, over
// WINDOW_SLOTS-1, and each mean is that channel's slot sum over WINDOW_SLOTS. A pulse edge
// adds a write-back state (read-modify-write of the bin memory), a tick without a report
// needs no state beyond its acceptance, and a reporting tick goes through acceptance, a
// scan of every memory entry, a drain of the read pipeline, a divider load and the estimate
// and correction steps of the reciprocal divider, and then the load of the output
// register. A report that finds the previous one still unread waits in the divider and
// stalls the input until the output is taken. A finished report sits in the output
// register while new transactions are taken. Both memories come out of reset empty
// through per-entry valid bits, so no clearing pass is needed.
`timescale 1ns / 1ps

module windowed_pulse_rate_and_sample_averager (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [9:0]  sample_a,
  input  logic [9:0]  sample_b,
  input  logic [9:0]  sample_c,
  input  logic [9:0]  sample_d,
  input  logic [9:0]  sample_e,
  input  logic [9:0]  sample_f,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pulse_rate,
  output logic [9:0]  mean_a,
  output logic [9:0]  mean_b,
  output logic [9:0]  mean_c,
  output logic [9:0]  mean_d,
  output logic [9:0]  mean_e,
  output logic [9:0]  mean_f,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PULSE = 6'b000010,
    S_SCAN  = 6'b000100,
    S_DRAIN = 6'b001000,
    S_LOAD  = 6'b010000,
    S_DIV   = 6'b100000
  } state_t;

  state_t state;

  // configuration
  logic [15:0] report_gap;
  logic [9:0]  bin_length;
  logic [9:0]  sample_period;

  // timing state
  logic [wpr_pkg::IDX_W-1:0] current_bin;
  logic [wpr_pkg::IDX_W-1:0] current_slot;
  logic [9:0]                ms_in_bin;
  logic [9:0]                ms_in_slot;
  logic [15:0]               ms_since_report;

  logic [wpr_pkg::WINDOW_SLOTS-1:0] bin_valid;
  logic [wpr_pkg::WINDOW_SLOTS-1:0] ring_valid;

  // memory ports
  logic                        bin_we;
  logic [wpr_pkg::IDX_W-1:0]   bin_waddr;
  logic [wpr_pkg::BIN_W-1:0]   bin_wdata;
  logic [wpr_pkg::IDX_W-1:0]   bin_raddr;
  logic [wpr_pkg::BIN_W-1:0]   bin_rdata;
  logic                        ring_we;
  logic [wpr_pkg::RING_W-1:0]  ring_wdata;
  logic [wpr_pkg::RING_W-1:0]  ring_rdata;

  // scan and accumulate
  logic [wpr_pkg::IDX_W-1:0]       scan_addr;
  logic [wpr_pkg::IDX_W-1:0]       acc_idx;
  logic                            acc_en;
  logic [wpr_pkg::PULSE_SUM_W-1:0] pulse_sum;
  logic [wpr_pkg::CH_SUM_W-1:0]    ch_sum [wpr_pkg::CHANNELS];

  wpr_pkg::div_lanes_t div_num;
  wpr_pkg::div_lanes_t div_quot;
  logic                div_start;
  logic                div_done;

  logic                 in_fire;
  logic                 tick_fire;
  logic                 pulse_fire;
  logic [10:0]          bin_ms_inc;
  logic [10:0]          slot_ms_inc;
  logic                 bin_roll;
  logic                 slot_roll;
  logic                 report_due;
  logic [wpr_pkg::IDX_W-1:0] bin_adv;
  logic [wpr_pkg::IDX_W-1:0] slot_adv;
  logic [wpr_pkg::BIN_W-1:0] bin_cur;
  logic                 out_load;

  assign in_ready   = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_fire    = in_valid && in_ready;
  assign tick_fire  = in_fire && !action;
  assign pulse_fire = in_fire && action;

  // Tick bookkeeping; a zero length compares true every tick, which acts like one
  assign bin_ms_inc  = {1'b0, ms_in_bin} + 11'd1;
  assign slot_ms_inc = {1'b0, ms_in_slot} + 11'd1;
  assign bin_roll    = (bin_ms_inc >= {1'b0, bin_length});
  assign slot_roll   = (slot_ms_inc >= {1'b0, sample_period});
  assign report_due  = (ms_since_report >= report_gap);
  assign bin_adv     = wpr_pkg::next_index(current_bin);
  assign slot_adv    = wpr_pkg::next_index(current_slot);

  // Bin memory: cleared entry on advance, saturating increment on a pulse
  assign bin_cur = bin_valid[current_bin] ? bin_rdata : '0;

  always_comb begin
    bin_we    = 1'b0;
    bin_waddr = current_bin;
    bin_wdata = '0;
    if (state == S_PULSE) begin
      bin_we    = 1'b1;
      bin_wdata = (bin_cur == wpr_pkg::BIN_MAX) ? bin_cur : wpr_pkg::BIN_W'(bin_cur + 1'b1);
    end else if (tick_fire && bin_roll) begin
      bin_we    = 1'b1;
      bin_waddr = bin_adv;
    end
  end

  // The FSM runs one transaction at a time, so every write lands before the next read
  assign bin_raddr  = (state == S_IDLE) ? current_bin : scan_addr;
  assign ring_we    = tick_fire && slot_roll;
  assign ring_wdata = {sample_f, sample_e, sample_d, sample_c, sample_b, sample_a};

  wpr_ram #(
    .WIDTH (wpr_pkg::BIN_W),
    .DEPTH (wpr_pkg::WINDOW_SLOTS)
  ) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  wpr_ram #(
    .WIDTH (wpr_pkg::RING_W),
    .DEPTH (wpr_pkg::WINDOW_SLOTS)
  ) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot_adv),
    .wdata (ring_wdata),
    .raddr (scan_addr),
    .rdata (ring_rdata)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      report_gap    <= 16'd250;
      bin_length    <= 10'd1000;
      sample_period <= 10'd25;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wpr_pkg::REG_REPORT_GAP:    report_gap    <= cfg_data;
        wpr_pkg::REG_BIN_LENGTH:    bin_length    <= cfg_data[9:0];
        wpr_pkg::REG_SAMPLE_PERIOD: sample_period <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Timing counters, ring pointers and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      current_bin     <= '0;
      current_slot    <= '0;
      ms_in_bin       <= '0;
      ms_in_slot      <= '0;
      ms_since_report <= '0;
      bin_valid       <= '0;
      ring_valid      <= '0;
    end else begin
      if (bin_we) begin
        bin_valid[bin_waddr] <= 1'b1;
      end
      if (tick_fire) begin
        if (bin_roll) begin
          ms_in_bin   <= '0;
          current_bin <= bin_adv;
        end else begin
          ms_in_bin <= bin_ms_inc[9:0];
        end
        if (slot_roll) begin
          ms_in_slot           <= '0;
          current_slot         <= slot_adv;
          ring_valid[slot_adv] <= 1'b1;
        end else begin
          ms_in_slot <= slot_ms_inc[9:0];
        end
        ms_since_report <= report_due ? 16'd0 : 16'(ms_since_report + 1'b1);
      end
    end
  end

  // Control sequencer
  assign div_start = (state == S_LOAD);
  assign out_load  = (state == S_DIV) && div_done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_addr <= '0;
      acc_en    <= 1'b0;
    end else begin
      acc_en <= 1'b0;
      unique case (state)
        S_IDLE: begin
          scan_addr <= '0;
          if (pulse_fire) begin
            state <= S_PULSE;
          end else if (tick_fire && report_due) begin
            state <= S_SCAN;
          end
        end
        S_PULSE: state <= S_IDLE;
        S_SCAN: begin
          acc_en <= 1'b1;
          if (scan_addr == wpr_pkg::LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            scan_addr <= wpr_pkg::IDX_W'(scan_addr + 1'b1);
          end
        end
        S_DRAIN: state <= S_LOAD;
        S_LOAD:  state <= S_DIV;
        S_DIV: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Accumulators follow the read address in the cycle after it is presented
  always_ff @(posedge clk) begin
    acc_idx <= scan_addr;
    if (state == S_IDLE) begin
      pulse_sum <= '0;
      for (int c = 0; c < wpr_pkg::CHANNELS; c++) begin
        ch_sum[c] <= '0;
      end
    end else if (acc_en) begin
      if (bin_valid[acc_idx] && (acc_idx != current_bin)) begin
        pulse_sum <= pulse_sum + wpr_pkg::PULSE_SUM_W'(bin_rdata);
      end
      if (ring_valid[acc_idx]) begin
        for (int c = 0; c < wpr_pkg::CHANNELS; c++) begin
          ch_sum[c] <= ch_sum[c] +
                       wpr_pkg::CH_SUM_W'(ring_rdata[c*wpr_pkg::SAMPLE_W +: wpr_pkg::SAMPLE_W]);
        end
      end
    end
  end

  // Division operands
  always_comb begin
    div_num[0] = wpr_pkg::DIV_W'(pulse_sum) *
                 wpr_pkg::DIV_W'(wpr_pkg::PULSES_PER_MIN_SCALE);
    for (int c = 0; c < wpr_pkg::CHANNELS; c++) begin
      div_num[c+1] = wpr_pkg::DIV_W'(ch_sum[c]);
    end
  end

  wpr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .quotient (div_quot),
    .done     (div_done)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pulse_rate <= 32'(div_quot[0]);
      mean_a     <= div_quot[1][9:0];
      mean_b     <= div_quot[2][9:0];
      mean_c     <= div_quot[3][9:0];
      mean_d     <= div_quot[4][9:0];
      mean_e     <= div_quot[5][9:0];
      mean_f     <= div_quot[6][9:0];
    end
  end

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    $rose(div_done) |-> (state == S_DIV))
    else $error("divider finished outside the divide state");

  assert property (@(posedge clk) disable iff (rst)
    (bin_we && (state == S_PULSE)) |-> (bin_wdata != '0))
    else $error("pulse write-back produced an empty bin");

  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DIV))
    else $error("result presented without a finished report");

endmodule

/* bench/tb_windowed_pulse_rate_and_sample_averager.sv */
`timescale 1ns / 1ps
// Self-checking bench for windowed_pulse_rate_and_sample_averager: directed and random
// pulse/tick traffic, register sweeps and output back-pressure, checked against a local predictor.
// Depends on wpr_pkg and the design sources only.

module tb_windowed_pulse_rate_and_sample_averager;

  localparam int SLOTS            = wpr_pkg::WINDOW_SLOTS;
  localparam int CH               = wpr_pkg::CHANNELS;
  localparam int DRAIN_CYCLES     = 2 * (SLOTS + wpr_pkg::DIV_W + 3);
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASES           = 8;
  localparam int PHASE_ITEMS      = 225;

  localparam logic        ACT_TICK     = 1'b0;
  localparam logic        ACT_PULSE    = 1'b1;
  localparam logic [1:0]  REG_UNMAPPED = 2'd3;
  localparam logic [15:0] BIN_FULL     = 16'hFFFF;

  typedef struct packed {
    logic            action;
    logic [5:0][9:0] samples;   // [0] is channel a
  } meter_item_t;

  typedef struct packed {
    logic [31:0]     rate;
    logic [5:0][9:0] means;
  } meter_report_t;

  // DUT connections; the ones the bench drives are known from time zero
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        action;
  logic [9:0]  sample_a, sample_b, sample_c, sample_d, sample_e, sample_f;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pulse_rate;
  logic [9:0]  mean_a, mean_b, mean_c, mean_d, mean_e, mean_f;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_data = 16'd0;

  meter_item_t drv_item = '0;

  assign action   = drv_item.action;
  assign sample_a = drv_item.samples[0];
  assign sample_b = drv_item.samples[1];
  assign sample_c = drv_item.samples[2];
  assign sample_d = drv_item.samples[3];
  assign sample_e = drv_item.samples[4];
  assign sample_f = drv_item.samples[5];

  windowed_pulse_rate_and_sample_averager dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .sample_a   (sample_a),
    .sample_b   (sample_b),
    .sample_c   (sample_c),
    .sample_d   (sample_d),
    .sample_e   (sample_e),
    .sample_f   (sample_f),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pulse_rate (pulse_rate),
    .mean_a     (mean_a),
    .mean_b     (mean_b),
    .mean_c     (mean_c),
    .mean_d     (mean_d),
    .mean_e     (mean_e),
    .mean_f     (mean_f),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Run limit
  initial begin
    #150_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Predicted meter state and register copies
  logic [15:0]     gap_reg     = 16'd250;
  logic [9:0]      bin_len_reg = 10'd1000;
  logic [9:0]      period_reg  = 10'd25;
  logic [15:0]     bin_count    [SLOTS] = '{default: '0};
  logic [5:0][9:0] slot_samples [SLOTS] = '{default: '0};
  int unsigned     cur_bin   = 0;
  int unsigned     cur_slot  = 0;
  int unsigned     ms_bin    = 0;
  int unsigned     ms_slot   = 0;
  logic [15:0]     ms_report = 16'd0;

  meter_item_t   pending_items[$];
  meter_report_t expected_reports[$];
  int unsigned   items_queued   = 0;
  int unsigned   items_accepted = 0;
  int unsigned   mismatches     = 0;

  bit sender_idle_en   = 1'b1;
  bit receiver_idle_en = 1'b1;
  bit hold_request     = 1'b0;
  bit hold_taken;
  int unsigned hold_left;
  int unsigned tx_gap;
  int unsigned rx_stall;

  // Advance the meter by one transaction; returns 1 when a report falls out
  function automatic bit advance_meter(input meter_item_t item, output meter_report_t rep);
    longint unsigned pulses;
    longint unsigned sums [CH];
    rep = '0;
    if (item.action == ACT_PULSE) begin
      if (bin_count[cur_bin] != BIN_FULL) bin_count[cur_bin]++;
      return 1'b0;
    end
    // bin advance, then slot advance, then the report check
    ms_bin++;
    if (ms_bin >= bin_len_reg) begin
      ms_bin = 0;
      cur_bin = (cur_bin + 1 == SLOTS) ? 0 : cur_bin + 1;
      bin_count[cur_bin] = '0;
    end
    ms_slot++;
    if (ms_slot >= period_reg) begin
      ms_slot = 0;
      cur_slot = (cur_slot + 1 == SLOTS) ? 0 : cur_slot + 1;
      slot_samples[cur_slot] = item.samples;
    end
    if (ms_report < gap_reg) begin
      ms_report++;
      return 1'b0;
    end
    ms_report = '0;
    pulses = 0;
    foreach (sums[c]) sums[c] = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i != cur_bin) pulses += bin_count[i];
      for (int c = 0; c < CH; c++) sums[c] += slot_samples[i][c];
    end
    rep.rate = 32'((pulses * 60) / (SLOTS - 1));
    for (int c = 0; c < CH; c++) rep.means[c] = 10'(sums[c] / SLOTS);
    return 1'b1;
  endfunction

  function automatic meter_item_t tick_with(input logic [5:0][9:0] s);
    meter_item_t it;
    it.action  = ACT_TICK;
    it.samples = s;
    return it;
  endfunction

  // Random samples lean on the range ends
  function automatic meter_item_t random_item(input int unsigned pulse_pct);
    meter_item_t it;
    it.action = ($urandom_range(0, 99) < pulse_pct) ? ACT_PULSE : ACT_TICK;
    for (int c = 0; c < CH; c++) begin
      case ($urandom_range(0, 9))
        0:       it.samples[c] = 10'd0;
        1:       it.samples[c] = 10'd1023;
        default: it.samples[c] = 10'($urandom_range(0, 1023));
      endcase
    end
    return it;
  endfunction

  function automatic logic [15:0] pick_length();
    logic [9:0] len;
    case ($urandom_range(0, 7))
      0:       len = 10'd0;
      1:       len = 10'd1023;
      default: len = 10'($urandom_range(1, 20));
    endcase
    // upper bits are junk the block must drop
    return {6'($urandom), len};
  endfunction

  task automatic queue_item(input meter_item_t it);
    pending_items.push_back(it);
    items_queued++;
  endtask

  // One register write; the predictor copy changes at the handshake
  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      wpr_pkg::REG_REPORT_GAP:    gap_reg     = value;
      wpr_pkg::REG_BIN_LENGTH:    bin_len_reg = value[9:0];
      wpr_pkg::REG_SAMPLE_PERIOD: period_reg  = value[9:0];
      default: ;
    endcase
  endtask

  // Wait until every queued item went in and every report came out, then drain
  task automatic settle();
    do @(negedge clk); while (items_accepted != items_queued || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic log_mismatch(input string what, input meter_report_t want,
                              input meter_report_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s at %0t: rate exp %0d got %0d; ",
                "means exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d"},
               what, $time, want.rate, got.rate,
               want.means[0], want.means[1], want.means[2],
               want.means[3], want.means[4], want.means[5],
               got.means[0], got.means[1], got.means[2],
               got.means[3], got.means[4], got.means[5]);
  endtask

  // Input driver: presents queued items, random idle bursts between them
  always @(posedge clk) begin : drive_items
    meter_report_t rep;
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        items_accepted++;
        if (advance_meter(drv_item, rep)) expected_reports.push_back(rep);
      end
      if (!in_valid || in_ready) begin
        if (tx_gap != 0) begin
          tx_gap   <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
          in_valid <= 1'b0;
        end else if (sender_idle_en && $urandom_range(0, 7) == 0) begin
          tx_gap   <= $urandom_range(0, 18);
          in_valid <= 1'b0;
        end else begin
          drv_item <= pending_items.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Long receiver hold, one per request
  always @(posedge clk) begin : long_hold
    if (rst) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request != hold_taken) begin
      hold_left  <= LONG_HOLD_CYCLES;
      hold_taken <= hold_request;
    end
  end

  // Report monitor and output back-pressure
  always @(posedge clk) begin : check_reports
    meter_report_t want, got;
    bit bad;
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.rate  = pulse_rate;
        got.means = {mean_f, mean_e, mean_d, mean_c, mean_b, mean_a};
        if (expected_reports.size() == 0) begin
          log_mismatch("unexpected report", '0, got);
        end else begin
          want = expected_reports.pop_front();
          bad  = (want.rate !== got.rate);
          for (int c = 0; c < CH; c++)
            if (want.means[c] !== got.means[c]) bad = 1'b1;
          if (bad) log_mismatch("report mismatch", want, got);
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall  <= rx_stall - 1;
        out_ready <= 1'b0;
      end else if (receiver_idle_en && $urandom_range(0, 9) == 0) begin
        rx_stall  <= $urandom_range(0, 18);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus sequence
  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: unknown index ignored, zero gap reports every tick, zero lengths act as one
    write_reg(REG_UNMAPPED, 16'hFFFF);
    write_reg(wpr_pkg::REG_REPORT_GAP, 16'd0);
    write_reg(wpr_pkg::REG_BIN_LENGTH, 16'd0);
    write_reg(wpr_pkg::REG_SAMPLE_PERIOD, 16'd0);
    queue_item(tick_with('0));
    queue_item(tick_with({6{10'h3FF}}));
    repeat (3) queue_item(random_item(100));
    queue_item(tick_with({6{10'h155}}));
    queue_item(tick_with({6{10'h2AA}}));
    queue_item(tick_with({10'h3FF, 10'h000, 10'h3FF, 10'h000, 10'h3FF, 10'h000}));
    // full ring of maximum samples drives every mean to its top
    repeat (12) queue_item(tick_with({6{10'h3FF}}));
    queue_item(random_item(100));
    queue_item(tick_with('0));
    settle();

    // Longest bin and period, then shortened below the running counters
    write_reg(wpr_pkg::REG_REPORT_GAP, 16'd3);
    write_reg(wpr_pkg::REG_BIN_LENGTH, 16'd1023);
    write_reg(wpr_pkg::REG_SAMPLE_PERIOD, 16'd1023);
    repeat (40) queue_item(random_item(30));
    settle();
    write_reg(wpr_pkg::REG_BIN_LENGTH, 16'd5);
    write_reg(wpr_pkg::REG_SAMPLE_PERIOD, 16'd7);
    repeat (40) queue_item(random_item(30));
    settle();

    // Widest report gap stays quiet, then every tick reports with one-tick bins
    sender_idle_en = 1'b0;
    write_reg(wpr_pkg::REG_REPORT_GAP, 16'hFFFF);
    write_reg(wpr_pkg::REG_BIN_LENGTH, 16'd1023);
    repeat (40) queue_item(random_item(50));
    settle();
    write_reg(wpr_pkg::REG_REPORT_GAP, 16'd0);
    write_reg(wpr_pkg::REG_BIN_LENGTH, 16'd1);
    repeat (12) queue_item(random_item(0));
    settle();
    sender_idle_en = 1'b1;

    // Receiver holds off while every tick reports, so the block backs up
    write_reg(wpr_pkg::REG_BIN_LENGTH, 16'd2);
    write_reg(wpr_pkg::REG_SAMPLE_PERIOD, 16'd1);
    hold_request = ~hold_request;
    repeat (80) queue_item(random_item(25));
    settle();

    // Random phases, each with fresh settings; the last one runs without idling
    for (int p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) begin
        sender_idle_en   = 1'b0;
        receiver_idle_en = 1'b0;
      end
      case ($urandom_range(0, 7))
        0:       write_reg(wpr_pkg::REG_REPORT_GAP, 16'd0);
        1:       write_reg(wpr_pkg::REG_REPORT_GAP, 16'd1);
        default: write_reg(wpr_pkg::REG_REPORT_GAP, 16'($urandom_range(2, 15)));
      endcase
      write_reg(wpr_pkg::REG_BIN_LENGTH, pick_length());
      write_reg(wpr_pkg::REG_SAMPLE_PERIOD, pick_length());
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNMAPPED, 16'($urandom));
      repeat (PHASE_ITEMS) queue_item(random_item(35));
      settle();
    end

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* filelist.f */
design/wpr_pkg.sv
design/wpr_ram.sv
design/wpr_div.sv
design/windowed_pulse_rate_and_sample_averager.sv
bench/tb_windowed_pulse_rate_and_sample_averager.sv
